### rtl/rgb_to_hsl_converter_top_defines.svh
// Assertion macros shared by the RGB to HSL converter checker.
// Each macro expands to one labeled concurrent assertion on i_clk.
`ifndef RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// Assertion that is switched off while the synchronous reset is held.
`define RHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Assertion that also watches the reset behavior.
`define RHC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/rhc_pkg.sv
// Package for the RGB to HSL converter: payload structs, widths and constants.
// No dependencies; used by every module of the converter.
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CH_W       = 8;     // one color channel
    localparam int HUE_W      = 15;    // hue in 1/64 degree
    localparam int SAT_W      = 8;
    localparam int LIGHT_W    = 8;
    localparam int SUM_W      = CH_W + 1;
    localparam int DIFF_W     = CH_W + 1;
    localparam int T_W        = 11;    // hue numerator in sextant steps, up to 6*255
    localparam int HNUM_W     = 23;    // T times 3840
    localparam int SNUM_W     = 16;    // 255 times chroma

    // 3840 = 4096 - 256, so one sextant is a shift-subtract.
    localparam int SEXT_HI_SH = 12;
    localparam int SEXT_LO_SH = 8;
    localparam int FULL_TURN  = 23040;
    localparam int CH_MAX     = 255;
    localparam int DEN_WRAP   = 510;

    // Input register, two arithmetic stages, one stage per hue quotient bit,
    // and the output register.
    localparam int PIPE_DEPTH = 4 + HUE_W;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]   hue_out;
        logic [SAT_W-1:0]   sat_out;
        logic [LIGHT_W-1:0] light_out;
    } t_hsl;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    // Operands and partial results that travel down the divider pipeline.
    typedef struct packed {
        logic [HNUM_W-1:0]  h_rem;
        logic [CH_W-1:0]    h_den;
        logic [HUE_W-1:0]   h_quo;
        logic [SNUM_W-1:0]  s_rem;
        logic [CH_W-1:0]    s_den;
        logic [SAT_W-1:0]   s_quo;
        logic [LIGHT_W-1:0] light;
    } t_div_work;

endpackage

### rtl/rhc_div_pipe.sv
// Pipelined restoring divider for hue and saturation, one hue quotient bit per stage.
// Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_div_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rhc_pkg::t_div_work i_work,
    output logic               o_valid,
    output rhc_pkg::t_hsl      o_hsl
);
    import rhc_pkg::*;

    localparam int STAGES = HUE_W;

    t_div_work          w_src  [STAGES];
    t_div_work          n_work [STAGES];
    t_div_work          r_work [STAGES];
    logic [STAGES-1:0]  r_vld;

    always_comb begin
        w_src[0] = i_work;
        for (int i = 1; i < STAGES; i++) begin
            w_src[i] = r_work[i-1];
        end
    end

    // Stage i decides quotient bit STAGES-1-i; the saturation quotient only
    // has SAT_W bits, so it is decided in the last SAT_W stages.
    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            logic [HNUM_W-1:0] v_hsub;
            logic [SNUM_W-1:0] v_ssub;
            v_hsub    = HNUM_W'(w_src[i].h_den) << (STAGES - 1 - i);
            v_ssub    = SNUM_W'(w_src[i].s_den) << (STAGES - 1 - i);
            n_work[i] = w_src[i];
            if (w_src[i].h_rem >= v_hsub) begin
                n_work[i].h_rem = w_src[i].h_rem - v_hsub;
                n_work[i].h_quo = {w_src[i].h_quo[HUE_W-2:0], 1'b1};
            end else begin
                n_work[i].h_quo = {w_src[i].h_quo[HUE_W-2:0], 1'b0};
            end
            if ((STAGES - 1 - i) < SAT_W) begin
                if (w_src[i].s_rem >= v_ssub) begin
                    n_work[i].s_rem = w_src[i].s_rem - v_ssub;
                    n_work[i].s_quo = {w_src[i].s_quo[SAT_W-2:0], 1'b1};
                end else begin
                    n_work[i].s_quo = {w_src[i].s_quo[SAT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STAGES; i++) begin
            r_work[i] <= n_work[i];
        end
    end

    assign o_valid         = r_vld[STAGES-1];
    assign o_hsl.hue_out   = r_work[STAGES-1].h_quo;
    assign o_hsl.sat_out   = r_work[STAGES-1].s_quo;
    assign o_hsl.light_out = r_work[STAGES-1].light;

endmodule

### rtl/rgb_to_hsl_converter_top.sv
// Top level of the RGB to HSL converter: channel compare, numerator setup,
// divider pipeline and output register. Depends on rhc_pkg and rhc_div_pipe.
`timescale 1ns / 1ps

// The converter takes one 8-bit RGB pixel per clock and returns hue in 1/64
// degree (0 to 23039), saturation and lightness (0 to 255, where 255 means
// 1.0), all truncated. A pixel transfer happens at a rising edge where start
// is high and busy is low. Busy is high only while reset is held and in the
// first cycle after it is released, so pixels may be sent back to back, one
// per clock, without limit. Every pixel gives exactly one result, in the
// order the pixels came in. The result is shown on o_hsl for one cycle with
// o_strobe high and is transferred at the edge that ends that cycle. The
// receiver cannot hold results off, so it must take every strobed result as
// it comes. Most of the pipeline is the divider: hue and saturation are each
// a quotient by the chroma or by the lightness term, and the divider pipeline
// decides one hue quotient bit per stage over 15 stages. Around it sit the
// input register, a stage that finds the largest and smallest channel, a stage
// that forms the numerators and denominators, and the output register. Grey
// pixels, where all channels are equal, give a hue and a saturation of zero.
// When two channels tie for the largest, red is preferred over green and
// green over blue.
module rgb_to_hsl_converter_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rhc_pkg::t_pixel i_pixel,
    output logic            o_strobe,
    output rhc_pkg::t_hsl   o_hsl
);
    import rhc_pkg::*;

    // Busy only covers reset; the pipeline itself never stalls.
    logic r_busy;

    // Stage 1: registered pixel.
    logic   r_s1_vld;
    t_pixel r_s1_pix;

    // Stage 2: chroma, max+min, winning channel and the signed difference
    // of the other two channels that goes into the hue.
    logic                     r_s2_vld;
    logic [CH_W-1:0]          r_s2_c;
    logic [SUM_W-1:0]         r_s2_sum;
    t_chan                    r_s2_chan;
    logic signed [DIFF_W-1:0] r_s2_diff;
    logic [CH_W-1:0]          n_s2_c;
    logic [SUM_W-1:0]         n_s2_sum;
    t_chan                    n_s2_chan;
    logic signed [DIFF_W-1:0] n_s2_diff;

    // Stage 3: divider operands.
    logic      r_s3_vld;
    t_div_work r_s3_work;
    t_div_work n_s3_work;

    logic w_div_vld;
    t_hsl w_div_hsl;

    // Output register.
    logic r_strobe;
    t_hsl r_hsl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_s1_vld <= start && !r_busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_strobe <= w_div_vld;
        end
    end

    // Stage 2 logic: the tie order red, green, blue falls out of the
    // greater-or-equal compares.
    always_comb begin
        logic [CH_W-1:0] v_r;
        logic [CH_W-1:0] v_g;
        logic [CH_W-1:0] v_b;
        logic [CH_W-1:0] v_max;
        logic [CH_W-1:0] v_min;
        v_r = r_s1_pix.red_in;
        v_g = r_s1_pix.green_in;
        v_b = r_s1_pix.blue_in;
        if (v_r >= v_g && v_r >= v_b) begin
            n_s2_chan = CH_RED;
            v_max     = v_r;
            n_s2_diff = $signed({1'b0, v_g}) - $signed({1'b0, v_b});
        end else if (v_g >= v_b) begin
            n_s2_chan = CH_GREEN;
            v_max     = v_g;
            n_s2_diff = $signed({1'b0, v_b}) - $signed({1'b0, v_r});
        end else begin
            n_s2_chan = CH_BLUE;
            v_max     = v_b;
            n_s2_diff = $signed({1'b0, v_r}) - $signed({1'b0, v_g});
        end
        v_min = v_r;
        if (v_g < v_min) begin
            v_min = v_g;
        end
        if (v_b < v_min) begin
            v_min = v_b;
        end
        n_s2_c   = v_max - v_min;
        n_s2_sum = SUM_W'(v_max) + SUM_W'(v_min);
    end

    // Stage 3 logic: the hue numerator is (sextant offset times chroma plus
    // the difference) times 3840, which keeps it non-negative. Red with a
    // negative difference wraps around through six sextants.
    always_comb begin
        logic [T_W-1:0]        v_base;
        logic signed [T_W:0]   v_tsum;
        logic [T_W-1:0]        v_t;
        logic [CH_W-1:0]       v_den;
        case (r_s2_chan)
            CH_RED: begin
                if (r_s2_diff < 0) begin
                    v_base = (T_W'(r_s2_c) << 2) + (T_W'(r_s2_c) << 1);
                end else begin
                    v_base = '0;
                end
            end
            CH_GREEN: v_base = T_W'(r_s2_c) << 1;
            CH_BLUE:  v_base = T_W'(r_s2_c) << 2;
            default:  v_base = '0;
        endcase
        v_tsum = $signed({1'b0, v_base}) + (T_W + 1)'(r_s2_diff);
        v_t    = v_tsum[T_W-1:0];

        if (r_s2_sum <= SUM_W'(CH_MAX)) begin
            v_den = r_s2_sum[CH_W-1:0];
        end else begin
            v_den = CH_W'(SUM_W'(DEN_WRAP) - r_s2_sum);
        end

        n_s3_work.h_rem = (HNUM_W'(v_t) << SEXT_HI_SH) - (HNUM_W'(v_t) << SEXT_LO_SH);
        n_s3_work.h_den = r_s2_c;
        n_s3_work.h_quo = '0;
        n_s3_work.s_rem = (SNUM_W'(r_s2_c) << CH_W) - SNUM_W'(r_s2_c);
        n_s3_work.s_den = v_den;
        n_s3_work.s_quo = '0;
        n_s3_work.light = r_s2_sum[SUM_W-1:1];

        // Grey pixel: divide zero by one so hue and saturation come out zero.
        if (r_s2_c == '0) begin
            n_s3_work.h_rem = '0;
            n_s3_work.h_den = CH_W'(1);
            n_s3_work.s_rem = '0;
            n_s3_work.s_den = CH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix  <= i_pixel;
        r_s2_c    <= n_s2_c;
        r_s2_sum  <= n_s2_sum;
        r_s2_chan <= n_s2_chan;
        r_s2_diff <= n_s2_diff;
        r_s3_work <= n_s3_work;
        r_hsl     <= w_div_hsl;
    end

    rhc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_vld),
        .i_work  (r_s3_work),
        .o_valid (w_div_vld),
        .o_hsl   (w_div_hsl)
    );

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_hsl    = r_hsl;

endmodule

### rtl/rhc_checker.sv
// Port-level checker for the RGB to HSL converter, bound to the top level.
// Depends on rhc_pkg and rgb_to_hsl_converter_top_defines.svh.
`timescale 1ns / 1ps
`include "rgb_to_hsl_converter_top_defines.svh"

module rhc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input rhc_pkg::t_pixel i_pixel,
    input logic            o_strobe,
    input rhc_pkg::t_hsl   o_hsl
);
    import rhc_pkg::*;

    logic w_accept;
    logic w_grey;

    assign w_accept = start && !busy;
    assign w_grey   = (i_pixel.red_in == i_pixel.green_in)
                   && (i_pixel.green_in == i_pixel.blue_in);

    // Reset holds off pixel transfers.
    `RHC_ASSERT_RST(a_busy_in_reset, !i_rst_n |=> busy, "busy low during reset")

    // Every result comes from a pixel transfer a fixed pipeline depth back.
    `RHC_ASSERT(a_strobe_origin, o_strobe |-> $past(w_accept, PIPE_DEPTH), "result without pixel")

    // Hue stays below a full turn.
    `RHC_ASSERT(a_hue_range, o_strobe |-> o_hsl.hue_out < HUE_W'(FULL_TURN), "hue out of range")

    // A grey pixel gives zero hue and saturation and its own level as lightness.
    `RHC_ASSERT(a_grey, o_strobe && $past(w_accept && w_grey, PIPE_DEPTH) |-> o_hsl.hue_out == '0 && o_hsl.sat_out == '0 && o_hsl.light_out == $past(i_pixel.red_in, PIPE_DEPTH), "grey pixel result wrong")

endmodule

bind rgb_to_hsl_converter_top rhc_checker u_rhc_checker (.*);
